@@ src/prq_pkg.sv @@
`timescale 1ns / 1ps
package prq_pkg;
	localparam int NUM_LEVELS_DEF = 256;
	localparam int NUM_TASKS_DEF = 32;
	localparam int KIND_W = 2;
	localparam int TASK_W = 5;
	localparam int PRIO_W = 8;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_INIT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_PICK = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ALREADY = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TASK_W-1:0] task_id;
		logic [PRIO_W-1:0] prio;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic found;
		logic [TASK_W-1:0] chosen_task;
		logic [PRIO_W-1:0] chosen_level;
	} rsp_t;
endpackage

@@ src/prq_cmd_fifo.sv @@
`timescale 1ns / 1ps
// two-entry command queue between the front end and the executor
module prq_cmd_fifo (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input prq_pkg::cmd_t in_cmd,
	output logic out_valid,
	input logic out_ready,
	output prq_pkg::cmd_t out_cmd
);
	prq_pkg::cmd_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_cmd = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("fifo count overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0) else $error("pop from empty fifo");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("fifo lost entry");
endmodule

@@ src/prq_exec.sv @@
`timescale 1ns / 1ps
// simple dual-port ram, registered read
module prq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic wr_en,
	input logic [ADDR_W-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data_q <= mem_q[rd_addr];
	end
endmodule

// executes one command at a time; level head/tail pointers live in a ram
module prq_exec #(
	parameter int NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF,
	parameter int NUM_TASKS = prq_pkg::NUM_TASKS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input prq_pkg::cmd_t cmd,
	output logic rsp_valid,
	input logic rsp_ready,
	output prq_pkg::rsp_t rsp
);
	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int TW = $clog2(NUM_TASKS);
	localparam int PW = TW + 1;
	localparam logic [PW-1:0] EMPTY = PW'(NUM_TASKS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [NUM_LEVELS-1:0] ne_q;
	logic [PW-1:0] link_q [NUM_TASKS];
	logic [NUM_TASKS-1:0] queued_q;

	logic [1:0] state_q;
	prq_pkg::cmd_t cmd_q;
	logic [LW-1:0] lvl_q;
	logic [PW-1:0] cur_q, prev_q;
	logic [PW-1:0] hd_q, tl_q;
	logic [PW:0] steps_q;
	prq_pkg::rsp_t rsp_q;
	logic rsp_valid_q;

	logic take;
	logic t_ok, l_ok;
	logic [TW-1:0] tid_in, tid, cur_i, prev_i;
	logic [LW-1:0] lvl_in;
	logic [LW-1:0] pick_lvl;
	logic pick_any;
	prq_pkg::rsp_t rsp_take;
	logic walk_end, walk_hit;
	logic ram_we;
	logic [LW-1:0] ram_waddr, ram_raddr;
	logic [2*PW-1:0] ram_wdata, ram_rdata;
	logic [PW-1:0] rd_head, rd_tail;

	assign cmd_ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign take = cmd_valid && cmd_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign t_ok = ({3'd0, cmd.task_id} < 8'(NUM_TASKS)) || (NUM_TASKS > 32);
	assign l_ok = ({1'b0, cmd.prio} < 9'(NUM_LEVELS));
	assign lvl_in = LW'(cmd.prio);
	assign tid_in = TW'(cmd.task_id);
	assign tid = TW'(cmd_q.task_id);
	assign cur_i = cur_q[TW-1:0];
	assign prev_i = prev_q[TW-1:0];
	assign pick_any = |ne_q;
	assign rd_head = ram_rdata[2*PW-1:PW];
	assign rd_tail = ram_rdata[PW-1:0];
	assign ram_raddr = (cmd.kind == prq_pkg::KIND_PICK) ? pick_lvl : lvl_in;
	assign walk_end = (steps_q == (PW+1)'(NUM_TASKS)) || (cur_q >= EMPTY);
	assign walk_hit = !walk_end && (cur_q == PW'(cmd_q.task_id));

	// highest-priority non-empty level
	always_comb begin
		pick_lvl = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (ne_q[i]) pick_lvl = LW'(i);
		end
	end

	always_comb begin
		rsp_take = '0;
		if (cmd.kind == prq_pkg::KIND_ADD) begin
			if (!t_ok || !l_ok) rsp_take.status = prq_pkg::ST_NOT_QUEUED;
			else if (queued_q[tid_in]) rsp_take.status = prq_pkg::ST_ALREADY;
		end else if (cmd.kind == prq_pkg::KIND_REMOVE) begin
			if (!t_ok || !l_ok || !queued_q[tid_in] || !ne_q[lvl_in])
				rsp_take.status = prq_pkg::ST_NOT_QUEUED;
		end
	end

	// head/tail entry of a level is only meaningful while its non-empty flag is set
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = lvl_q;
		ram_wdata = {hd_q, tl_q};
		unique case (state_q)
			S_IDLE: begin
				ram_waddr = LW'(NUM_LEVELS - 1);
				ram_wdata = {PW'(cmd.task_id), PW'(cmd.task_id)};
				ram_we = take && (cmd.kind == prq_pkg::KIND_INIT) && t_ok;
			end
			S_READ: begin
				if (ne_q[lvl_q]) ram_wdata = {rd_head, PW'(cmd_q.task_id)};
				else ram_wdata = {PW'(cmd_q.task_id), PW'(cmd_q.task_id)};
				ram_we = (cmd_q.kind == prq_pkg::KIND_ADD);
			end
			S_WALK: begin
				if (walk_hit) begin
					if (prev_q >= EMPTY) begin
						ram_wdata = {link_q[cur_i], tl_q};
						ram_we = (tl_q != cur_q);
					end else begin
						ram_wdata = {hd_q, prev_q};
						ram_we = (tl_q == cur_q);
					end
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	prq_ram #(.WIDTH(2 * PW), .DEPTH(NUM_LEVELS), .ADDR_W(LW)) u_level_ram (
		.clk(clk),
		.wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
		.rd_addr(ram_raddr), .rd_data(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (take) cmd_q <= cmd;
	end

	// a tail's link is never followed, so stale links need no clearing
	always_ff @(posedge clk) begin
		if (state_q == S_READ && cmd_q.kind == prq_pkg::KIND_ADD && ne_q[lvl_q])
			link_q[rd_tail[TW-1:0]] <= PW'(cmd_q.task_id);
		else if (state_q == S_WALK && walk_hit && prev_q < EMPTY)
			link_q[prev_i] <= link_q[cur_i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ne_q <= '0;
			queued_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
			lvl_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			hd_q <= '0;
			tl_q <= '0;
			steps_q <= '0;
		end else begin
			if (state_q == S_DONE) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						rsp_q <= rsp_take;
						lvl_q <= ram_raddr;
						unique case (cmd.kind)
							prq_pkg::KIND_INIT: begin
								ne_q <= t_ok ? {1'b1, {(NUM_LEVELS-1){1'b0}}} : '0;
								queued_q <= t_ok ? (NUM_TASKS'(1) << tid_in) : '0;
								state_q <= S_DONE;
							end
							prq_pkg::KIND_ADD: begin
								state_q <= (rsp_take.status != prq_pkg::ST_OK) ? S_DONE : S_READ;
							end
							prq_pkg::KIND_REMOVE: begin
								state_q <= (rsp_take.status != prq_pkg::ST_OK) ? S_DONE : S_READ;
							end
							prq_pkg::KIND_PICK: begin
								state_q <= pick_any ? S_READ : S_DONE;
							end
						endcase
					end
				end
				S_READ: begin
					if (cmd_q.kind == prq_pkg::KIND_ADD) begin
						ne_q[lvl_q] <= 1'b1;
						queued_q[tid] <= 1'b1;
						state_q <= S_DONE;
					end else if (cmd_q.kind == prq_pkg::KIND_REMOVE) begin
						hd_q <= rd_head;
						tl_q <= rd_tail;
						cur_q <= rd_head;
						prev_q <= EMPTY;
						steps_q <= '0;
						state_q <= S_WALK;
					end else begin
						rsp_q <= '{status: prq_pkg::ST_OK, found: 1'b1,
							chosen_task: prq_pkg::TASK_W'(rd_head),
							chosen_level: prq_pkg::PRIO_W'(lvl_q)};
						state_q <= S_DONE;
					end
				end
				S_WALK: begin
					if (walk_end) begin
						rsp_q.status <= prq_pkg::ST_NOT_QUEUED;
						state_q <= S_DONE;
					end else if (walk_hit) begin
						if (prev_q >= EMPTY && tl_q == cur_q) ne_q[lvl_q] <= 1'b0;
						queued_q[cur_i] <= 1'b0;
						state_q <= S_DONE;
					end else if (tl_q == cur_q) begin
						rsp_q.status <= prq_pkg::ST_NOT_QUEUED;
						state_q <= S_DONE;
					end else begin
						prev_q <= cur_q;
						cur_q <= link_q[cur_i];
						steps_q <= steps_q + 1'b1;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !rsp_valid_q) else $error("command taken while result pending");
	a_done_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> rsp_valid_q) else $error("result not raised");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("result changed while waiting");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> steps_q <= (PW+1)'(NUM_TASKS)) else $error("walk overrun");
endmodule

@@ src/priority_ready_queue_scheduler_unit.sv @@
`timescale 1ns / 1ps
// Ready queue with per-level FIFOs of task ids; level 0 is highest. Commands enter a
// two-entry queue and are carried out one at a time by the executor, one result per
// command; the executor takes the next command only after its result has been transferred.
// Level head/tail pointers sit in a RAM with registered read, guarded by per-level
// non-empty flags, so neither reset nor init sweeps the levels. Init, a pick that finds nothing
// and a rejected add or remove go straight to the result; add and a successful pick first do
// one RAM read; remove reads the level's head and tail from the RAM and then walks the level's
// links one task per cycle until it finds the task, reaches the tail or has visited NUM_TASKS
// tasks.
module priority_ready_queue_scheduler_unit #(
	parameter int NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF,
	parameter int NUM_TASKS = prq_pkg::NUM_TASKS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [15:0] s_axis_tdata, // kind[1:0], task_id[6:2], priority_req[14:7]
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [15:0] m_axis_tdata // status[1:0], found[2], chosen_task[7:3], chosen_level[15:8]
);
	prq_pkg::cmd_t in_cmd, q_cmd;
	prq_pkg::rsp_t rsp;
	logic q_valid, q_ready;

	assign in_cmd.kind = s_axis_tdata[1:0];
	assign in_cmd.task_id = s_axis_tdata[6:2];
	assign in_cmd.prio = s_axis_tdata[14:7];

	prq_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
		.out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
	);

	prq_exec #(.NUM_LEVELS(NUM_LEVELS), .NUM_TASKS(NUM_TASKS)) u_exec (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.rsp_valid(m_axis_tvalid), .rsp_ready(m_axis_tready), .rsp(rsp)
	);

	assign m_axis_tdata = {rsp.chosen_level, rsp.chosen_task, rsp.found, rsp.status};
endmodule

@@ verif/priority_ready_queue_scheduler_unit_tb.sv @@
`timescale 1ns / 1ps
module priority_ready_queue_scheduler_unit_tb;
	localparam int NLVL = prq_pkg::NUM_LEVELS_DEF;
	localparam int NTSK = prq_pkg::NUM_TASKS_DEF;
	localparam int EMPTY = NTSK;

	class ready_queue_scoreboard;
		int head [NLVL];
		int tail [NLVL];
		bit nonempty [NLVL];
		int link [NTSK];
		bit queued [NTSK];
		prq_pkg::rsp_t pending [$];
		int mismatches;
		int checked;

		function void clear_levels();
			for (int i = 0; i < NLVL; i++) begin
				head[i] = EMPTY;
				tail[i] = EMPTY;
				nonempty[i] = 0;
			end
			for (int i = 0; i < NTSK; i++) begin
				link[i] = 0;
				queued[i] = 0;
			end
		endfunction

		function void push_tail(int lvl, int t);
			if (nonempty[lvl]) begin
				link[tail[lvl]] = t;
			end else begin
				head[lvl] = t;
				nonempty[lvl] = 1;
			end
			tail[lvl] = t;
			link[t] = EMPTY;
			queued[t] = 1;
		endfunction

		function logic [prq_pkg::STATUS_W-1:0] unlink(int lvl, int t);
			int cur;
			int prev;
			if (!nonempty[lvl]) return prq_pkg::ST_NOT_QUEUED;
			cur = head[lvl];
			prev = EMPTY;
			for (int s = 0; s < NTSK; s++) begin
				if (cur >= NTSK) return prq_pkg::ST_NOT_QUEUED;
				if (cur == t) begin
					if (prev == EMPTY) begin
						if (tail[lvl] == t) begin
							nonempty[lvl] = 0;
							head[lvl] = EMPTY;
							tail[lvl] = EMPTY;
						end else begin
							head[lvl] = link[t];
						end
					end else begin
						link[prev] = link[t];
						if (tail[lvl] == t) tail[lvl] = prev;
					end
					link[t] = EMPTY;
					queued[t] = 0;
					return prq_pkg::ST_OK;
				end
				if (tail[lvl] == cur) return prq_pkg::ST_NOT_QUEUED;
				prev = cur;
				cur = link[cur];
			end
			return prq_pkg::ST_NOT_QUEUED;
		endfunction

		function void note_command(prq_pkg::cmd_t c);
			prq_pkg::rsp_t r;
			r = '0;
			r.status = prq_pkg::ST_OK;
			case (c.kind)
				prq_pkg::KIND_INIT: begin
					clear_levels();
					push_tail(NLVL - 1, int'(c.task_id));
				end
				prq_pkg::KIND_ADD: begin
					if (queued[c.task_id]) r.status = prq_pkg::ST_ALREADY;
					else push_tail(int'(c.prio), int'(c.task_id));
				end
				prq_pkg::KIND_REMOVE: begin
					if (!queued[c.task_id]) r.status = prq_pkg::ST_NOT_QUEUED;
					else r.status = unlink(int'(c.prio), int'(c.task_id));
				end
				default: begin
					for (int i = 0; i < NLVL; i++) begin
						if (nonempty[i]) begin
							r.found = 1'b1;
							r.chosen_task = 5'(head[i]);
							r.chosen_level = 8'(i);
							break;
						end
					end
				end
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(prq_pkg::rsp_t got);
			prq_pkg::rsp_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			exp = pending.pop_front();
			checked++;
			if (got.status !== exp.status || got.found !== exp.found ||
					got.chosen_task !== exp.chosen_task ||
					got.chosen_level !== exp.chosen_level) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp st=%0d f=%0d t=%0d l=%0d got st=%0d f=%0d t=%0d l=%0d",
						exp.status, exp.found, exp.chosen_task, exp.chosen_level,
						got.status, got.found, got.chosen_task, got.chosen_level);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata; // kind, task_id, priority_req
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [15:0] m_axis_tdata; // status, found, chosen_task, chosen_level

	priority_ready_queue_scheduler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	ready_queue_scoreboard board;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_off_cycles;
	int cmds_sent;
	int kinds_seen [4];

	function automatic prq_pkg::rsp_t unpack_rsp(logic [15:0] d);
		prq_pkg::rsp_t r;
		r.status = d[1:0];
		r.found = d[2];
		r.chosen_task = d[7:3];
		r.chosen_level = d[15:8];
		return r;
	endfunction

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) board.check_result(unpack_rsp(m_axis_tdata));
			if (hold_off_cycles > 0) begin
				hold_off_cycles <= hold_off_cycles - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_cmd(logic [prq_pkg::KIND_W-1:0] kind, logic [prq_pkg::TASK_W-1:0] tid,
			logic [prq_pkg::PRIO_W-1:0] prio);
		prq_pkg::cmd_t c;
		c.kind = kind;
		c.task_id = tid;
		c.prio = prio;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, c.prio, c.task_id, c.kind};
		do @(posedge clk); while (!s_axis_tready);
		board.note_command(c);
		cmds_sent++;
		kinds_seen[kind]++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending.size() != 0);
	endtask

	// task ids over the full range; mostly high levels (0 to 15) so that picks stay cheap
	task automatic random_cmd();
		int r;
		logic [prq_pkg::TASK_W-1:0] tid;
		logic [prq_pkg::PRIO_W-1:0] prio;
		r = $urandom_range(99);
		tid = 5'($urandom_range(31));
		prio = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
		if (r < 2) begin
			send_cmd(prq_pkg::KIND_INIT, tid, 8'($urandom_range(255)));
		end else if (r < 40) begin
			send_cmd(prq_pkg::KIND_ADD, tid, prio);
		end else if (r < 70) begin
			// mostly removes of queued tasks at their real level
			if ($urandom_range(3) != 0 && board.queued[tid]) begin
				for (int l = 0; l < NLVL; l++) begin
					int cur;
					cur = board.head[l];
					if (board.nonempty[l]) begin
						for (int s = 0; s < NTSK && cur < NTSK; s++) begin
							if (cur == tid) prio = 8'(l);
							if (cur == board.tail[l]) break;
							cur = board.link[cur];
						end
					end
				end
			end
			send_cmd(prq_pkg::KIND_REMOVE, tid, prio);
		end else begin
			send_cmd(prq_pkg::KIND_PICK, tid, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		board = new();
		board.clear_levels();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_cycles = 0;
		cmds_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pick, extremes, double add, missing remove, init
		send_cmd(prq_pkg::KIND_PICK, 5'd0, 8'd0);
		send_cmd(prq_pkg::KIND_REMOVE, 5'd3, 8'd0);
		send_cmd(prq_pkg::KIND_ADD, 5'd31, 8'd255);
		send_cmd(prq_pkg::KIND_ADD, 5'd0, 8'd255);
		send_cmd(prq_pkg::KIND_ADD, 5'd1, 8'd0);
		send_cmd(prq_pkg::KIND_ADD, 5'd1, 8'd7);
		send_cmd(prq_pkg::KIND_PICK, 5'd31, 8'd255);
		send_cmd(prq_pkg::KIND_ADD, 5'd2, 8'd0);
		send_cmd(prq_pkg::KIND_ADD, 5'd3, 8'd0);
		send_cmd(prq_pkg::KIND_REMOVE, 5'd2, 8'd1);
		send_cmd(prq_pkg::KIND_REMOVE, 5'd2, 8'd0);
		send_cmd(prq_pkg::KIND_REMOVE, 5'd3, 8'd0);
		send_cmd(prq_pkg::KIND_PICK, 5'd0, 8'd0);
		send_cmd(prq_pkg::KIND_REMOVE, 5'd1, 8'd0);
		send_cmd(prq_pkg::KIND_PICK, 5'd0, 8'd0);
		send_cmd(prq_pkg::KIND_REMOVE, 5'd0, 8'd255);
		send_cmd(prq_pkg::KIND_PICK, 5'd0, 8'd0);
		send_cmd(prq_pkg::KIND_INIT, 5'd31, 8'd170);
		send_cmd(prq_pkg::KIND_PICK, 5'd0, 8'd0);
		send_cmd(prq_pkg::KIND_ADD, 5'd31, 8'd85);
		send_cmd(prq_pkg::KIND_INIT, 5'd0, 8'd0);
		send_cmd(prq_pkg::KIND_REMOVE, 5'd0, 8'd255);
		send_cmd(prq_pkg::KIND_PICK, 5'd21, 8'd0);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 52 : 0;
			recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 27 : 0;
			for (int i = 0; i < 550; i++) begin
				if (i == 100) hold_off_cycles = 300;
				if (i == 300) drain();
				random_cmd();
			end
		end

		drain();
		repeat (300) @(posedge clk);
		$display("sent %0d commands (init %0d, add %0d, remove %0d, pick %0d), checked %0d",
			cmds_sent, kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3],
			board.checked);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule

@@ filelist.f @@
src/prq_pkg.sv
src/prq_cmd_fifo.sv
src/prq_exec.sv
src/priority_ready_queue_scheduler_unit.sv
verif/priority_ready_queue_scheduler_unit_tb.sv
